// ===== rtl/core/gpt_pkg.sv =====
// Shared types and constants for the grid persistence tagger.
package gpt_pkg;

    // Default sizing
    localparam int MAX_CELLS_DEF  = 65536;
    localparam int COUNT_BITS_DEF = 8;

    // Fixed field widths
    localparam int SAMPLE_W    = 32;
    localparam int CELL_IDX_W  = 16;
    localparam int STEPS_W     = 8;
    localparam int GRID_W      = 17;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int WARMUP_W    = 8;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;

    // Comparison codes; codes 6 and 7 never match
    typedef enum logic [MODE_W-1:0] {
        CMP_GT = 3'd0,
        CMP_LT = 3'd1,
        CMP_GE = 3'd2,
        CMP_LE = 3'd3,
        CMP_EQ = 3'd4,
        CMP_NE = 3'd5
    } cmp_mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPARE_MODE  = 3'd0,
        CFG_THRESHOLD     = 3'd1,
        CFG_FILL_VALUE    = 3'd2,
        CFG_PERSIST_STEPS = 3'd3,
        CFG_GRID_CELLS    = 3'd4
    } cfg_index_t;

    // Item kinds on the input side
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

endpackage

// ===== rtl/core/gpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/grid_persistence_tagger_unit.sv =====
// Persistence tagger: frames of grid samples arrive in raster order; each cell keeps a run
// counter and a countdown in one RAM word (run count low, countdown high). An item is read
// from the RAM the cycle it is accepted, updated in the update stage and written back as
// that stage moves on, with the write forwarded when the following item hits the same cell
// (tiny frames), so the block takes one item per clock while the output does not stall.
// After reset a clearing pass zeroes all MAX_CELLS entries, one entry per cycle, while
// s_axis_tready stays low; configuration writes are taken throughout.
module grid_persistence_tagger_unit #(
    parameter int MAX_CELLS  = gpt_pkg::MAX_CELLS_DEF,
    parameter int COUNT_BITS = gpt_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [gpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [gpt_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] sample
    input  logic [gpt_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // [0] op, [1] not_a_number
    // Result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [gpt_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [0] tag, [16:1] cell_index, rest 0
    output logic                           m_axis_tlast   // last_cell
);

    localparam int POS_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CW        = (POS_W + 1 > gpt_pkg::GRID_W) ? POS_W + 1 : gpt_pkg::GRID_W;
    localparam int PW        = (COUNT_BITS > gpt_pkg::STEPS_W) ? COUNT_BITS : gpt_pkg::STEPS_W;
    localparam int ENTRY_W   = 2 * COUNT_BITS;
    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
    localparam int PAD_W     = gpt_pkg::M_TDATA_W - gpt_pkg::CELL_IDX_W - 1;

    // Configuration registers
    logic [gpt_pkg::MODE_W-1:0]         cmp_mode_reg;
    logic signed [gpt_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [gpt_pkg::SAMPLE_W-1:0]       fill_value_reg;
    logic [gpt_pkg::STEPS_W-1:0]        persist_steps_reg;
    logic [gpt_pkg::GRID_W-1:0]         grid_cells_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_mode_reg      <= gpt_pkg::CMP_GT;
            threshold_reg     <= '0;
            fill_value_reg    <= '0;
            persist_steps_reg <= gpt_pkg::STEPS_W'(1);
            grid_cells_reg    <= gpt_pkg::GRID_W'(65536);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gpt_pkg::CFG_COMPARE_MODE:  cmp_mode_reg      <= cfg_wdata[gpt_pkg::MODE_W-1:0];
                gpt_pkg::CFG_THRESHOLD:     threshold_reg     <= cfg_wdata;
                gpt_pkg::CFG_FILL_VALUE:    fill_value_reg    <= cfg_wdata;
                gpt_pkg::CFG_PERSIST_STEPS: persist_steps_reg <= cfg_wdata[gpt_pkg::STEPS_W-1:0];
                gpt_pkg::CFG_GRID_CELLS:    grid_cells_reg    <= cfg_wdata[gpt_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Input field unpacking
    logic                                in_op;
    logic                                in_nan;
    logic signed [gpt_pkg::SAMPLE_W-1:0] in_sample;
    assign in_op     = s_axis_tuser[0];
    assign in_nan    = s_axis_tuser[1];
    assign in_sample = s_axis_tdata;

    // Control state
    logic             clearing_reg;
    logic [POS_W-1:0] clr_addr_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [gpt_pkg::WARMUP_W-1:0] warmup_reg;

    logic s_fire;
    logic s1_go;

    // Effective persistence length and frame size
    logic [gpt_pkg::STEPS_W-1:0] steps_nz;
    logic [PW-1:0]               p_eff;
    logic [CW-1:0]               cells_eff;
    logic [CW-1:0]               pos_plus;
    logic                        last0;
    logic                        emit0;
    logic                        cmp_hit;
    logic                        ok0;

    always_comb begin
        steps_nz = (persist_steps_reg == '0) ? gpt_pkg::STEPS_W'(1) : persist_steps_reg;
        p_eff    = (PW'(steps_nz) > PW'(COUNT_MAX)) ? PW'(COUNT_MAX) : PW'(steps_nz);

        if (grid_cells_reg == '0) begin
            cells_eff = CW'(1);
        end else if (CW'(grid_cells_reg) > CW'(MAX_CELLS)) begin
            cells_eff = CW'(MAX_CELLS);
        end else begin
            cells_eff = CW'(grid_cells_reg);
        end
        pos_plus = CW'(pos_reg) + CW'(1);
        last0    = (pos_plus >= cells_eff);
        pos_next = last0 ? '0 : pos_plus[POS_W-1:0];

        // Flush always emits; samples wait out the warm-up frames
        emit0 = (in_op == gpt_pkg::OP_FLUSH) ||
                ((PW+1)'(warmup_reg) + (PW+1)'(1) >= (PW+1)'(p_eff));

        case (cmp_mode_reg)
            gpt_pkg::CMP_GT: cmp_hit = (in_sample >  threshold_reg);
            gpt_pkg::CMP_LT: cmp_hit = (in_sample <  threshold_reg);
            gpt_pkg::CMP_GE: cmp_hit = (in_sample >= threshold_reg);
            gpt_pkg::CMP_LE: cmp_hit = (in_sample <= threshold_reg);
            gpt_pkg::CMP_EQ: cmp_hit = (in_sample == threshold_reg);
            gpt_pkg::CMP_NE: cmp_hit = (in_sample != threshold_reg);
            default:         cmp_hit = 1'b0;
        endcase
        ok0 = !in_nan && (in_sample != fill_value_reg) && cmp_hit;
    end

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // Clearing pass, position and warm-up counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            pos_reg      <= '0;
            warmup_reg   <= '0;
        end else begin
            if (clearing_reg) begin
                clr_addr_reg <= clr_addr_reg + POS_W'(1);
                if (clr_addr_reg == POS_W'(MAX_CELLS - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (s_fire) begin
                pos_reg <= pos_next;
                if (in_op == gpt_pkg::OP_SAMPLE && last0 && warmup_reg != '1) begin
                    warmup_reg <= warmup_reg + gpt_pkg::WARMUP_W'(1);
                end
            end
        end
    end

    // Update stage registers
    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic               s1_ok_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic [PW-1:0]      s1_p_reg;
    logic               fwd_hit_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;

    logic [ENTRY_W-1:0]    ram_rdata;
    logic [ENTRY_W-1:0]    entry;
    logic [COUNT_BITS-1:0] rc;
    logic [COUNT_BITS-1:0] cd;
    logic [COUNT_BITS-1:0] rc_next;
    logic [COUNT_BITS-1:0] cd_next;
    logic                  tag_next;
    logic                  out_free;

    // Read-modify-write of one cell
    always_comb begin
        entry    = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        rc       = entry[COUNT_BITS-1:0];
        cd       = entry[ENTRY_W-1:COUNT_BITS];
        rc_next  = rc;
        cd_next  = cd;
        tag_next = 1'b0;
        if (s1_op_reg == gpt_pkg::OP_SAMPLE) begin
            if (!s1_ok_reg) begin
                rc_next = '0;
            end else begin
                if (PW'(rc) < s1_p_reg) begin
                    rc_next = rc + COUNT_BITS'(1);
                end
                if (PW'(rc_next) >= s1_p_reg) begin
                    cd_next = s1_p_reg[COUNT_BITS-1:0];
                end
            end
        end
        if (s1_emit_reg && cd_next != '0) begin
            tag_next = 1'b1;
            cd_next  = cd_next - COUNT_BITS'(1);
        end
    end

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s1_go         = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_axis_tready = !clearing_reg && (!s1_valid_reg || s1_go);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
                // The write landing this cycle is not seen by the read issued now
                fwd_hit_reg  <= s1_go && (s1_pos_reg == pos_reg);
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_op_reg    <= in_op;
            s1_ok_reg    <= ok0;
            s1_emit_reg  <= emit0;
            s1_last_reg  <= last0;
            s1_pos_reg   <= pos_reg;
            s1_p_reg     <= p_eff;
            fwd_data_reg <= {cd_next, rc_next};
        end
    end

    // State memory
    logic               ram_wr_en;
    logic [POS_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;

    assign ram_wr_en   = clearing_reg || s1_go;
    assign ram_wr_addr = clearing_reg ? clr_addr_reg : s1_pos_reg;
    assign ram_wr_data = clearing_reg ? '0 : {cd_next, rc_next};

    gpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CELLS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s_fire),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    // Output register
    logic                            m_valid_reg;
    logic                            m_tag_reg;
    logic [gpt_pkg::CELL_IDX_W-1:0]  m_idx_reg;
    logic                            m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_emit_reg) begin
            m_tag_reg  <= tag_next;
            m_idx_reg  <= gpt_pkg::CELL_IDX_W'(s1_pos_reg);
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_idx_reg, m_tag_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule
